### src/ssdp_pkg.sv
// shared types and constants for the saturating signed decimal parser
// no dependencies; used by every module of the block
`default_nettype none

package ssdp_pkg;

  localparam int VALUE_BITS = 64;
  localparam int USED_BITS  = 12;
  localparam int TDATA_BITS = 80;
  localparam int INDEX_BITS = 2;

  localparam logic [USED_BITS-1:0] USED_MAX = 12'd4095;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [INDEX_BITS-1:0] REG_MAX_BYTES  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_LOW_LIMIT  = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_HIGH_LIMIT = 2'd2;

  localparam logic [VALUE_BITS-1:0] LOW_LIMIT_RESET  = 64'h8000_0000_0000_0000;
  localparam logic [62:0]           HIGH_LIMIT_RESET = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]            max_bytes;
    logic [VALUE_BITS-1:0] low_limit;
    logic [62:0]           high_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] parsed_value;
    logic [USED_BITS-1:0]  bytes_used;
    logic                  stopped_on_byte;
  } result_t;

endpackage

`default_nettype wire

### src/ssdp_cfg_regs.sv
// configuration registers: byte budget and the two saturation limits
// depends on ssdp_pkg
`default_nettype none

module ssdp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ssdp_pkg::INDEX_BITS-1:0] cfg_index,
  input  wire logic [ssdp_pkg::VALUE_BITS-1:0] cfg_data,
  output ssdp_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes  <= '0;
      cfg.low_limit  <= ssdp_pkg::LOW_LIMIT_RESET;
      cfg.high_limit <= ssdp_pkg::HIGH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ssdp_pkg::REG_MAX_BYTES:  cfg.max_bytes  <= cfg_data[7:0];
        ssdp_pkg::REG_LOW_LIMIT:  cfg.low_limit  <= cfg_data;
        ssdp_pkg::REG_HIGH_LIMIT: cfg.high_limit <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/ssdp_input_stage.sv
// input register: holds one accepted byte beat until the parse core takes it
// depends on ssdp_pkg
`default_nettype none

module ssdp_input_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic       s_tlast,   // last
  input  wire logic [0:0] s_tuser,   // first
  input  wire logic       fire,
  output logic            in_valid,
  output ssdp_pkg::beat_t beat
);

  // a held beat leaves on fire, so a new one may enter the same cycle
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.data_byte <= s_tdata;
      beat.first     <= s_tuser[0];
      beat.last      <= s_tlast;
    end
  end

endmodule

`default_nettype wire

### src/ssdp_parse_core.sv
// parse state and the per-byte update: sign, digit accumulate with clamp, end detect
// depends on ssdp_pkg
`default_nettype none

module ssdp_parse_core #(
  parameter int COUNT_BITS = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire ssdp_pkg::beat_t beat,
  input  wire ssdp_pkg::cfg_t  cfg,
  output logic            res_valid,
  output ssdp_pkg::result_t res
);

  localparam int VB   = ssdp_pkg::VALUE_BITS;
  localparam int UB   = ssdp_pkg::USED_BITS;
  localparam int WIDE = (COUNT_BITS > UB) ? COUNT_BITS : UB;
  localparam int ACC  = VB + 4;

  logic                  parsing_active;
  logic                  is_negative;
  logic [VB-1:0]         magnitude;
  logic [COUNT_BITS-1:0] byte_count;
  logic [7:0]            digit_budget;

  logic                  parsing_active_next;
  logic                  is_negative_next;
  logic [VB-1:0]         magnitude_next;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [7:0]            digit_budget_next;

  logic                  neg_base;
  logic [VB-1:0]         mag_base;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [7:0]            bud_base;
  logic                  is_sign;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [VB-1:0]         lim;
  logic [ACC-1:0]        acc;
  logic                  clamp;
  logic [VB-1:0]         mag_step;
  logic [COUNT_BITS-1:0] cnt_step;
  logic [VB-1:0]         emit_mag;
  logic [COUNT_BITS-1:0] emit_cnt;
  logic                  emit_neg;
  logic                  emit_stop;
  logic [WIDE-1:0]       cnt_wide;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic budget_hit(input logic [COUNT_BITS-1:0] c,
                                      input logic [7:0] bud);
    budget_hit = (bud != 8'd0) && (c >= COUNT_BITS'(bud));
  endfunction

  assign neg_base = beat.first ? 1'b0 : is_negative;
  assign mag_base = beat.first ? '0 : magnitude;
  assign cnt_base = beat.first ? '0 : byte_count;
  assign bud_base = beat.first ? cfg.max_bytes : digit_budget;

  assign is_sign  = (beat.data_byte == ssdp_pkg::CHAR_PLUS) ||
                    (beat.data_byte == ssdp_pkg::CHAR_MINUS);
  assign is_digit = (beat.data_byte >= ssdp_pkg::CHAR_ZERO) &&
                    (beat.data_byte <= ssdp_pkg::CHAR_NINE);
  assign digit    = 4'(beat.data_byte - ssdp_pkg::CHAR_ZERO);

  // a positive low limit acts as zero
  assign lim = neg_base ? (cfg.low_limit[VB-1] ? VB'(0) - cfg.low_limit : '0)
                        : {1'b0, cfg.high_limit};

  // exact magnitude*10 + digit, wide enough that nothing wraps
  assign acc      = (ACC'(mag_base) << 3) + (ACC'(mag_base) << 1) + ACC'(digit);
  assign clamp    = acc > ACC'(lim);
  assign mag_step = clamp ? lim : acc[VB-1:0];
  assign cnt_step = bump(cnt_base);

  always_comb begin
    parsing_active_next = parsing_active;
    is_negative_next    = is_negative;
    magnitude_next      = magnitude;
    byte_count_next     = byte_count;
    digit_budget_next   = digit_budget;
    res_valid           = 1'b0;
    emit_stop           = 1'b0;
    emit_mag            = mag_base;
    emit_cnt            = cnt_base;
    emit_neg            = neg_base;
    if (fire) begin
      if (beat.first && is_sign) begin
        is_negative_next    = (beat.data_byte == ssdp_pkg::CHAR_MINUS);
        magnitude_next      = '0;
        byte_count_next     = COUNT_BITS'(1);
        digit_budget_next   = cfg.max_bytes;
        res_valid           = beat.last || budget_hit(COUNT_BITS'(1), cfg.max_bytes);
        parsing_active_next = !res_valid;
        emit_mag            = '0;
        emit_cnt            = COUNT_BITS'(1);
      end else if (beat.first || parsing_active) begin
        is_negative_next  = neg_base;
        digit_budget_next = bud_base;
        if (!is_digit) begin
          // byte ends the parse and is left unconsumed
          magnitude_next      = mag_base;
          byte_count_next     = cnt_base;
          res_valid           = 1'b1;
          emit_stop           = 1'b1;
          parsing_active_next = 1'b0;
        end else begin
          magnitude_next      = mag_step;
          byte_count_next     = cnt_step;
          res_valid           = beat.last || budget_hit(cnt_step, bud_base);
          parsing_active_next = !res_valid;
          emit_mag            = mag_step;
          emit_cnt            = cnt_step;
        end
      end
    end
  end

  assign cnt_wide            = WIDE'(emit_cnt);
  assign res.bytes_used      = (cnt_wide > WIDE'(ssdp_pkg::USED_MAX)) ? ssdp_pkg::USED_MAX
                                                                     : cnt_wide[UB-1:0];
  assign res.parsed_value    = emit_neg ? VB'(0) - emit_mag : emit_mag;
  assign res.stopped_on_byte = emit_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      parsing_active <= 1'b0;
      is_negative    <= 1'b0;
      magnitude      <= '0;
      byte_count     <= '0;
      digit_budget   <= '0;
    end else begin
      parsing_active <= parsing_active_next;
      is_negative    <= is_negative_next;
      magnitude      <= magnitude_next;
      byte_count     <= byte_count_next;
      digit_budget   <= digit_budget_next;
    end
  end

endmodule

`default_nettype wire

### src/ssdp_output_stage.sv
// result register on the master side of the stream
// depends on ssdp_pkg
`default_nettype none

module ssdp_output_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            fire,
  input  wire logic                            res_valid,
  input  wire ssdp_pkg::result_t               res,
  output logic                                 room,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ssdp_pkg::TDATA_BITS-1:0]      m_tdata,  // parsed_value, bytes_used, pad
  output logic [0:0]                           m_tuser   // stopped_on_byte
);

  localparam int PAD = ssdp_pkg::TDATA_BITS - ssdp_pkg::VALUE_BITS - ssdp_pkg::USED_BITS;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      m_tdata    <= {PAD'(0), res.bytes_used, res.parsed_value};
      m_tuser[0] <= res.stopped_on_byte;
    end
  end

endmodule

`default_nettype wire

### src/saturating_signed_decimal_parser_unit.sv
// Saturating signed decimal parser. Takes one text byte per cycle and returns one result
// beat per parsed number: the signed value clamped to the configured limits, the bytes
// used (sign included, saturating at 4095) and whether the ending byte was left unconsumed.
// Sustained rate is one byte per cycle; the ending byte passes from the input register
// into the result register that drives m_tvalid. The rate is set by the per-byte update
// loop: magnitude*10 + digit and its 68-bit compare against the limit are combinational
// between the input register and the parse state. Backpressure on the master side stalls
// the input register only once the result register is full and not being taken.
// depends on ssdp_pkg and the ssdp_* submodules
`default_nettype none

module saturating_signed_decimal_parser_unit #(
  parameter int COUNT_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ssdp_pkg::INDEX_BITS-1:0] cfg_index,
  input  wire logic [ssdp_pkg::VALUE_BITS-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // data_byte
  input  wire logic                            s_tlast,   // last
  input  wire logic [0:0]                      s_tuser,   // first
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ssdp_pkg::TDATA_BITS-1:0]      m_tdata,   // parsed_value, bytes_used, pad
  output logic [0:0]                           m_tuser    // stopped_on_byte
);

  ssdp_pkg::cfg_t    cfg;
  ssdp_pkg::beat_t   beat;
  ssdp_pkg::result_t res;
  logic              in_valid;
  logic              room;
  logic              fire;
  logic              res_valid;

  assign fire = in_valid && room;

  ssdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssdp_input_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .fire     (fire),
    .in_valid (in_valid),
    .beat     (beat)
  );

  ssdp_parse_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (beat),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ssdp_output_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

### src/ssdp_checker.sv
// port-level checks for the parser top level, attached by bind
// depends on ssdp_pkg and saturating_signed_decimal_parser_unit
`default_nettype none

module ssdp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [ssdp_pkg::TDATA_BITS-1:0] m_tdata,
  input wire logic [0:0]                      m_tuser
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // nothing consumed means zero value and an unconsumed ending byte
  a_empty_parse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[75:64] == 12'd0 |-> m_tdata[63:0] == 64'd0 && m_tuser[0])
    else $error("empty parse with nonzero value or consumed ending byte");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[79:76] == 4'd0)
    else $error("pad bits of result beat not zero");

endmodule

bind saturating_signed_decimal_parser_unit ssdp_checker u_ssdp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
